>>> rtl/r2h_pkg.sv
package r2h_pkg;

   localparam int ChanW = 8;
   localparam int HueW = 15;
   localparam int SatW = 16;
   localparam int SatSteps = SatW;

   localparam int HueFracBitsDefault = 6;
   localparam int HueSpanDeg = 60;
   localparam int HueIntBits = $clog2(HueSpanDeg + 1);
   localparam int SectGreenDeg = 120;
   localparam int SectBlueDeg = 240;
   localparam int FullCircleDeg = 360;

   localparam logic [1:0] SectRed = 2'd0;
   localparam logic [1:0] SectGreen = 2'd1;
   localparam logic [1:0] SectBlue = 2'd2;

   typedef struct packed {
      logic       grey;
      logic       black;
      logic       full;
      logic       neg;
      logic [1:0] sector;
   } r2h_flags_type;

   typedef struct packed {
      r2h_flags_type     flags;
      logic [ChanW-1:0]  brightness;
      logic [ChanW-1:0]  alpha;
      logic [ChanW-1:0]  delta;
      logic [ChanW-1:0]  sat_rem;
      logic [SatW-1:0]   sat_q;
   } r2h_div_type;

endpackage

>>> rtl/r2h_chan_if.sv
interface r2h_req_if;
   logic                      valid;
   logic                      ready;
   logic [r2h_pkg::ChanW-1:0] red;
   logic [r2h_pkg::ChanW-1:0] green;
   logic [r2h_pkg::ChanW-1:0] blue;
   logic [r2h_pkg::ChanW-1:0] alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 output ready);
endinterface

interface r2h_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [r2h_pkg::HueW-1:0]  hue;
   logic [r2h_pkg::SatW-1:0]  saturation;
   logic [r2h_pkg::ChanW-1:0] brightness;
   logic [r2h_pkg::ChanW-1:0] alpha_out;

   modport source (output valid, output hue, output saturation, output brightness,
                   output alpha_out, input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 input alpha_out, output ready);
endinterface

>>> rtl/r2h_front.sv
module r2h_front #(
   parameter int HUE_FRAC_BITS = r2h_pkg::HueFracBitsDefault,
   localparam int QuotW = r2h_pkg::HueIntBits + HUE_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [r2h_pkg::ChanW-1:0] in_red,
   input  logic [r2h_pkg::ChanW-1:0] in_green,
   input  logic [r2h_pkg::ChanW-1:0] in_blue,
   input  logic [r2h_pkg::ChanW-1:0] in_alpha,
   output logic                      out_valid,
   input  logic                      out_ready,
   output r2h_pkg::r2h_div_type      out_data,
   output logic [r2h_pkg::ChanW-1:0] out_hue_rem,
   output logic [QuotW-1:0]          out_hue_bits,
   output logic [QuotW-1:0]          out_hue_q
);

   localparam int ChanW = r2h_pkg::ChanW;
   localparam int ProdW = ChanW + r2h_pkg::HueIntBits;
   localparam int DivdW = ChanW + QuotW;

   // stage a: max, min and sector
   logic             a_valid_ff;
   logic             a_ready;
   logic             b_valid_ff;
   logic             b_ready;
   logic [ChanW-1:0] a_red_ff, a_green_ff, a_blue_ff, a_alpha_ff;
   logic [ChanW-1:0] a_max_ff, a_min_ff;
   logic [1:0]       a_sector_ff;
   logic [ChanW-1:0] a_max_in, a_min_in;
   logic [1:0]       a_sector_in;

   always_comb begin
      if (in_red >= in_green && in_red >= in_blue) begin
         a_max_in = in_red;
         a_sector_in = r2h_pkg::SectRed;
      end else if (in_green >= in_blue) begin
         a_max_in = in_green;
         a_sector_in = r2h_pkg::SectGreen;
      end else begin
         a_max_in = in_blue;
         a_sector_in = r2h_pkg::SectBlue;
      end
      a_min_in = in_red;
      if (in_green < a_min_in) a_min_in = in_green;
      if (in_blue < a_min_in) a_min_in = in_blue;
   end

   assign in_ready = a_ready;
   assign a_ready = !a_valid_ff || b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         a_red_ff <= in_red;
         a_green_ff <= in_green;
         a_blue_ff <= in_blue;
         a_alpha_ff <= in_alpha;
         a_max_ff <= a_max_in;
         a_min_ff <= a_min_in;
         a_sector_ff <= a_sector_in;
      end
   end

   // stage b: delta, hue numerator and divider setup
   r2h_pkg::r2h_div_type b_data_ff, b_data_in;
   logic [ChanW-1:0]     b_hue_rem_ff, b_hue_rem_in;
   logic [QuotW-1:0]     b_hue_bits_ff, b_hue_bits_in;
   logic [ChanW-1:0]     delta;
   logic [ChanW:0]       num;
   logic [ChanW-1:0]     mag;
   logic [ProdW-1:0]     prod;
   logic [DivdW-1:0]     dividend;

   always_comb begin
      delta = a_max_ff - a_min_ff;
      case (a_sector_ff)
         r2h_pkg::SectRed: num = {1'b0, a_green_ff} - {1'b0, a_blue_ff};
         r2h_pkg::SectGreen: num = {1'b0, a_blue_ff} - {1'b0, a_red_ff};
         r2h_pkg::SectBlue: num = {1'b0, a_red_ff} - {1'b0, a_green_ff};
         default: num = '0;
      endcase
      mag = num[ChanW] ? ChanW'(-num) : num[ChanW-1:0];
      prod = ProdW'(mag) * ProdW'(r2h_pkg::HueSpanDeg);
      dividend = DivdW'(prod) << HUE_FRAC_BITS;
      b_hue_rem_in = dividend[DivdW-1 -: ChanW];
      b_hue_bits_in = dividend[QuotW-1:0];

      b_data_in.flags.grey = (delta == '0);
      b_data_in.flags.black = (a_max_ff == '0);
      b_data_in.flags.full = (delta == a_max_ff) && (a_max_ff != '0);
      b_data_in.flags.neg = num[ChanW];
      b_data_in.flags.sector = a_sector_ff;
      b_data_in.brightness = a_max_ff;
      b_data_in.alpha = a_alpha_ff;
      b_data_in.delta = delta;
      b_data_in.sat_rem = delta;
      b_data_in.sat_q = '0;
   end

   assign b_ready = !b_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_ready) begin
         b_data_ff <= b_data_in;
         b_hue_rem_ff <= b_hue_rem_in;
         b_hue_bits_ff <= b_hue_bits_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data = b_data_ff;
   assign out_hue_rem = b_hue_rem_ff;
   assign out_hue_bits = b_hue_bits_ff;
   assign out_hue_q = '0;

   // leading dividend bits must already sit below the divisor
   a_hue_init_below_delta: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_data_ff.flags.grey |-> b_hue_rem_ff < b_data_ff.delta)
      else $error("hue divider start remainder not below delta");

endmodule

>>> rtl/r2h_div_stage.sv
module r2h_div_stage #(
   parameter int HUE_FRAC_BITS = r2h_pkg::HueFracBitsDefault,
   parameter int STEP = 0,
   localparam int QuotW = r2h_pkg::HueIntBits + HUE_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  r2h_pkg::r2h_div_type      in_data,
   input  logic [r2h_pkg::ChanW-1:0] in_hue_rem,
   input  logic [QuotW-1:0]          in_hue_bits,
   input  logic [QuotW-1:0]          in_hue_q,
   output logic                      out_valid,
   input  logic                      out_ready,
   output r2h_pkg::r2h_div_type      out_data,
   output logic [r2h_pkg::ChanW-1:0] out_hue_rem,
   output logic [QuotW-1:0]          out_hue_bits,
   output logic [QuotW-1:0]          out_hue_q
);

   localparam int ChanW = r2h_pkg::ChanW;
   localparam int SatW = r2h_pkg::SatW;

   logic                 valid_ff;
   r2h_pkg::r2h_div_type data_ff, data_in;
   logic [ChanW-1:0]     hue_rem_ff, hue_rem_in;
   logic [QuotW-1:0]     hue_bits_ff, hue_bits_in;
   logic [QuotW-1:0]     hue_q_ff, hue_q_in;
   logic [ChanW:0]       sat_trial;
   logic                 sat_ge;

   // saturation: one quotient bit per stage
   always_comb begin
      sat_trial = {in_data.sat_rem, 1'b0};
      sat_ge = sat_trial >= {1'b0, in_data.brightness};
      data_in = in_data;
      data_in.sat_rem = sat_ge ? ChanW'(sat_trial - {1'b0, in_data.brightness})
                               : sat_trial[ChanW-1:0];
      data_in.sat_q = {in_data.sat_q[SatW-2:0], sat_ge};
   end

   // hue: one quotient bit per stage while quotient bits remain
   generate
      if (STEP < QuotW) begin : g_hue_step
         logic [ChanW:0] hue_trial;
         logic           hue_ge;
         always_comb begin
            hue_trial = {in_hue_rem, in_hue_bits[QuotW-1]};
            hue_ge = hue_trial >= {1'b0, in_data.delta};
            hue_rem_in = hue_ge ? ChanW'(hue_trial - {1'b0, in_data.delta})
                                : hue_trial[ChanW-1:0];
            hue_bits_in = {in_hue_bits[QuotW-2:0], 1'b0};
            hue_q_in = {in_hue_q[QuotW-2:0], hue_ge};
         end
      end else begin : g_hue_hold
         always_comb begin
            hue_rem_in = in_hue_rem;
            hue_bits_in = in_hue_bits;
            hue_q_in = in_hue_q;
         end
      end
   endgenerate

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
         hue_rem_ff <= hue_rem_in;
         hue_bits_ff <= hue_bits_in;
         hue_q_ff <= hue_q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
   assign out_hue_rem = hue_rem_ff;
   assign out_hue_bits = hue_bits_ff;
   assign out_hue_q = hue_q_ff;

   a_sat_rem_below_max: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.flags.black && !data_ff.flags.full
      |-> data_ff.sat_rem < data_ff.brightness)
      else $error("saturation remainder not below max");

   a_hue_rem_below_delta: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.flags.grey |-> hue_rem_ff < data_ff.delta)
      else $error("hue remainder not below delta");

endmodule

>>> rtl/r2h_back.sv
module r2h_back #(
   parameter int HUE_FRAC_BITS = r2h_pkg::HueFracBitsDefault,
   localparam int QuotW = r2h_pkg::HueIntBits + HUE_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  r2h_pkg::r2h_div_type      in_data,
   input  logic [r2h_pkg::ChanW-1:0] in_hue_rem,
   input  logic [QuotW-1:0]          in_hue_q,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [r2h_pkg::HueW-1:0]  out_hue,
   output logic [r2h_pkg::SatW-1:0]  out_saturation,
   output logic [r2h_pkg::ChanW-1:0] out_brightness,
   output logic [r2h_pkg::ChanW-1:0] out_alpha
);

   localparam int ChanW = r2h_pkg::ChanW;
   localparam int HueW = r2h_pkg::HueW;
   localparam int SatW = r2h_pkg::SatW;
   localparam int SumRaw = $clog2(r2h_pkg::FullCircleDeg << HUE_FRAC_BITS) + 2;
   localparam int SumW = (SumRaw > HueW) ? SumRaw : HueW + 1;

   logic             valid_ff;
   logic [HueW-1:0]  hue_ff, hue_in;
   logic [SatW-1:0]  sat_ff, sat_in;
   logic [ChanW-1:0] bright_ff, alpha_ff;
   logic [SumW-1:0]  mag, offset, base, sum, wrapped;

   always_comb begin
      // floor toward negative infinity: a nonzero remainder rounds a negative quotient down
      mag = SumW'(in_hue_q) + SumW'(in_data.flags.neg && (in_hue_rem != '0));
      offset = in_data.flags.neg ? -mag : mag;
      case (in_data.flags.sector)
         r2h_pkg::SectRed: base = '0;
         r2h_pkg::SectGreen: base = SumW'(r2h_pkg::SectGreenDeg << HUE_FRAC_BITS);
         r2h_pkg::SectBlue: base = SumW'(r2h_pkg::SectBlueDeg << HUE_FRAC_BITS);
         default: base = '0;
      endcase
      sum = base + offset;
      wrapped = sum[SumW-1] ? sum + SumW'(r2h_pkg::FullCircleDeg << HUE_FRAC_BITS) : sum;
      hue_in = in_data.flags.grey ? '0 : wrapped[HueW-1:0];

      if (in_data.flags.black) begin
         sat_in = '0;
      end else if (in_data.flags.full) begin
         sat_in = '1;
      end else begin
         sat_in = in_data.sat_q;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         bright_ff <= in_data.brightness;
         alpha_ff <= in_data.alpha;
      end
   end

   assign out_valid = valid_ff;
   assign out_hue = hue_ff;
   assign out_saturation = sat_ff;
   assign out_brightness = bright_ff;
   assign out_alpha = alpha_ff;

   a_hue_in_circle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (HUE_FRAC_BITS > 6) ||
                   (int'(hue_ff) < (r2h_pkg::FullCircleDeg << HUE_FRAC_BITS)))
      else $error("hue outside full circle");

endmodule

>>> rtl/rgb_to_hsv_convert_top.sv
// pipeline: 2 front stages, 16 divider stages and 1 output register between
// req item accept and rsp valid; the divider depth sets the latency
// throughput: one item per cycle unless rsp_ch.ready stalls; each divider stage
// resolves one quotient bit of saturation, and one of hue while hue bits remain
// reset: synchronous, clears the valid bit of every stage, payload is not cleared
module rgb_to_hsv_convert_top #(
   parameter int HUE_FRAC_BITS = r2h_pkg::HueFracBitsDefault
) (
   input logic          clock,
   input logic          reset,
   r2h_req_if.sink      req_ch,
   r2h_rsp_if.source    rsp_ch
);

   localparam int QuotW = r2h_pkg::HueIntBits + HUE_FRAC_BITS;
   localparam int Steps = r2h_pkg::SatSteps;

   logic                        stg_valid [0:Steps];
   logic                        stg_ready [0:Steps];
   r2h_pkg::r2h_div_type        stg_data [0:Steps];
   logic [r2h_pkg::ChanW-1:0]   stg_hue_rem [0:Steps];
   logic [QuotW-1:0]            stg_hue_bits [0:Steps];
   logic [QuotW-1:0]            stg_hue_q [0:Steps];

   r2h_front #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_ch.valid),
      .in_ready(req_ch.ready),
      .in_red(req_ch.red),
      .in_green(req_ch.green),
      .in_blue(req_ch.blue),
      .in_alpha(req_ch.alpha),
      .out_valid(stg_valid[0]),
      .out_ready(stg_ready[0]),
      .out_data(stg_data[0]),
      .out_hue_rem(stg_hue_rem[0]),
      .out_hue_bits(stg_hue_bits[0]),
      .out_hue_q(stg_hue_q[0])
   );

   generate
      for (genvar i = 0; i < Steps; i++) begin : g_div
         r2h_div_stage #(
            .HUE_FRAC_BITS(HUE_FRAC_BITS),
            .STEP(i)
         ) u_stage (
            .clock(clock),
            .reset(reset),
            .in_valid(stg_valid[i]),
            .in_ready(stg_ready[i]),
            .in_data(stg_data[i]),
            .in_hue_rem(stg_hue_rem[i]),
            .in_hue_bits(stg_hue_bits[i]),
            .in_hue_q(stg_hue_q[i]),
            .out_valid(stg_valid[i+1]),
            .out_ready(stg_ready[i+1]),
            .out_data(stg_data[i+1]),
            .out_hue_rem(stg_hue_rem[i+1]),
            .out_hue_bits(stg_hue_bits[i+1]),
            .out_hue_q(stg_hue_q[i+1])
         );
      end
   endgenerate

   r2h_back #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(stg_valid[Steps]),
      .in_ready(stg_ready[Steps]),
      .in_data(stg_data[Steps]),
      .in_hue_rem(stg_hue_rem[Steps]),
      .in_hue_q(stg_hue_q[Steps]),
      .out_valid(rsp_ch.valid),
      .out_ready(rsp_ch.ready),
      .out_hue(rsp_ch.hue),
      .out_saturation(rsp_ch.saturation),
      .out_brightness(rsp_ch.brightness),
      .out_alpha(rsp_ch.alpha_out)
   );

endmodule
